// ----- src/cd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the circular deque.
// Depends on nothing; every other file of the block imports it.
package cd_pkg;

  localparam int WordW = 32;
  localparam int OpW   = 3;
  localparam int StW   = 2;
  localparam int CapW  = 5;

  localparam logic [CapW-1:0]         CapReset = 5'd16;
  localparam logic signed [WordW-1:0] WordNone = 32'hFFFF_FFFF;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_NOP        = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_stat_t;

endpackage

// ----- src/cd_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the circular deque: valid, ready and one request.
// Depends on cd_pkg.
interface cd_req_if;
  import cd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          operation;
  logic signed [WordW-1:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

// ----- src/cd_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the circular deque: valid, ready and one result.
// Depends on cd_pkg.
interface cd_rsp_if;
  import cd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StW-1:0]          status;
  logic signed [WordW-1:0] popped_value;
  logic signed [WordW-1:0] front_value;
  logic signed [WordW-1:0] rear_value;
  logic                    is_empty;
  logic                    is_full;
  logic [CapW-1:0]         occupancy;

  modport source (output valid, output status, output popped_value, output front_value,
                  output rear_value, output is_empty, output is_full, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input front_value,
                  input rear_value, input is_empty, input is_full, input occupancy,
                  output ready);
endinterface

// ----- src/cd_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the circular deque and the result valid flag.
// Depends on cd_pkg; drives the command struct of cd_dp.
module cd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  cd_pkg::dp_stat_t stat_i,
  output cd_pkg::cmd_t    cmd_o
);
  import cd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_PUBLISH
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = (state_q == S_IDLE) && req_valid_i;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.load    = (state_q == S_LOAD);
    cmd_o.publish = (state_q == S_PUBLISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= stat_i.need_read ? S_LOAD : S_PUBLISH;
        end
        S_LOAD: begin
          state_q <= S_PUBLISH;
        end
        S_PUBLISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/cd_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the circular deque: ring store, indices, cached end words,
// capacity register and result register. Depends on cd_pkg; run by cd_ctrl.
module cd_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cd_pkg::CapW-1:0]       cfg_wdata_i,
  input  logic [cd_pkg::OpW-1:0]        operation_i,
  input  logic signed [cd_pkg::WordW-1:0] data_in_i,
  input  cd_pkg::cmd_t                  cmd_i,
  output cd_pkg::dp_stat_t              stat_o,
  output logic [cd_pkg::StW-1:0]        status_o,
  output logic signed [cd_pkg::WordW-1:0] popped_value_o,
  output logic signed [cd_pkg::WordW-1:0] front_value_o,
  output logic signed [cd_pkg::WordW-1:0] rear_value_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic [cd_pkg::CapW-1:0]       occupancy_o
);
  import cd_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CapMax = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CapW-1:0] CapMaxW = CapW'(CapMax);

  logic signed [WordW-1:0] mem [DEPTH];

  logic [CapW-1:0]         cap_q;
  logic [IdxW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CapW-1:0]         count_q, count_d;
  logic [OpW-1:0]          op_q;
  logic signed [WordW-1:0] word_q;
  logic signed [WordW-1:0] front_q, front_d, rear_q, rear_d;
  logic [StW-1:0]          status_q, status_d;
  logic signed [WordW-1:0] popped_q, popped_d;
  logic signed [WordW-1:0] rd_data_q;
  logic                    tgt_front_q, tgt_front_d;

  logic [CapW-1:0]         cap_eff;
  logic [IdxW-1:0]         cap_m1;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_addr, rd_addr;
  logic                    need_read;

  assign cap_eff = (cap_q == '0) ? CapW'(1) : ((cap_q > CapMaxW) ? CapMaxW : cap_q);
  assign cap_m1  = IdxW'(cap_eff - CapW'(1));

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    rear_d      = rear_q;
    status_d    = ST_DONE;
    popped_d    = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    rd_addr     = '0;
    need_read   = 1'b0;
    tgt_front_d = 1'b1;
    case (op_q)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (count_q >= cap_eff) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CapW'(1);
          if (count_q == '0) begin
            head_d  = '0;
            tail_d  = '0;
            wr_addr = '0;
            front_d = word_q;
            rear_d  = word_q;
          end else if (op_q == OP_PUSH_FRONT) begin
            head_d  = (head_q == '0) ? cap_m1 : head_q - IdxW'(1);
            wr_addr = head_d;
            front_d = word_q;
          end else begin
            tail_d  = (tail_q >= cap_m1) ? '0 : tail_q + IdxW'(1);
            wr_addr = tail_d;
            rear_d  = word_q;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
          popped_d = WordNone;
        end else if (count_q == CapW'(1)) begin
          popped_d = front_q;
          head_d   = '0;
          tail_d   = '0;
          count_d  = '0;
        end else if (op_q == OP_POP_FRONT) begin
          popped_d  = front_q;
          head_d    = (head_q >= cap_m1) ? '0 : head_q + IdxW'(1);
          count_d   = count_q - CapW'(1);
          rd_addr   = head_d;
          need_read = 1'b1;
        end else begin
          popped_d    = rear_q;
          tail_d      = (tail_q == '0) ? cap_m1 : tail_q - IdxW'(1);
          count_d     = count_q - CapW'(1);
          rd_addr     = tail_d;
          need_read   = 1'b1;
          tgt_front_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.need_read = need_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      cap_q   <= cfg_wdata_i;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      word_q <= data_in_i;
    end
    if (cmd_i.exec) begin
      front_q     <= front_d;
      rear_q      <= rear_d;
      status_q    <= status_d;
      popped_q    <= popped_d;
      tgt_front_q <= tgt_front_d;
      rd_data_q   <= mem[rd_addr];
      if (wr_en) begin
        mem[wr_addr] <= word_q;
      end
    end
    if (cmd_i.load) begin
      if (tgt_front_q) begin
        front_q <= rd_data_q;
      end else begin
        rear_q <= rd_data_q;
      end
    end
    if (cmd_i.publish) begin
      status_o       <= status_q;
      popped_value_o <= popped_q;
      front_value_o  <= (count_q == '0) ? WordNone : front_q;
      rear_value_o   <= (count_q == '0) ? WordNone : rear_q;
      is_empty_o     <= (count_q == '0);
      is_full_o      <= (count_q == cap_eff);
      occupancy_o    <= count_q;
    end
  end

endmodule

// ----- src/circular_deque.sv -----
`timescale 1ns / 1ps
// Top level of the circular deque: request and result channels, capacity port.
// Depends on cd_pkg, cd_req_if, cd_rsp_if, cd_ctrl and cd_dp.
//
// A double-ended queue of signed 32-bit words in a ring store of DEPTH entries, of which
// the capacity register puts min(max(capacity, 1), DEPTH) in use; writing it empties the
// queue. One request is worked at a time and is accepted only while the block is idle. A
// push, a rejected request or a pop that empties the queue goes from acceptance through an
// execute state to a publish state, where its result is registered. A pop that leaves
// words behind passes through a load state between the two, since the new end word comes
// from a registered read of the store. The publish state waits while the previous result
// still waits to be taken. The result register lets the next request be accepted while a
// result still waits to be taken. No clearing pass is needed after reset.
module circular_deque #(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [cd_pkg::CapW-1:0] cfg_wdata_i,
  cd_req_if.sink                  req_i,
  cd_rsp_if.source                rsp_o
);
  import cd_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  cd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (req_i.operation),
    .data_in_i      (req_i.data_in),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (rsp_o.status),
    .popped_value_o (rsp_o.popped_value),
    .front_value_o  (rsp_o.front_value),
    .rear_value_o   (rsp_o.rear_value),
    .is_empty_o     (rsp_o.is_empty),
    .is_full_o      (rsp_o.is_full),
    .occupancy_o    (rsp_o.occupancy)
  );

endmodule
